// File: hw/rtl/ptb_pkg.sv
// Shared types and constants for the periodic timer bank.
// Used by ptb_mod, ptb_datapath, ptb_ctrl and periodic_timer_bank_unit.
package ptb_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 5;
  localparam int CMD_W      = 4;
  localparam int EVT_W      = 8;
  localparam int AMT_W      = 16;
  localparam int REM_W      = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 4'd0,
    CMD_ADD     = 4'd1,
    CMD_SET_TO  = 4'd2,
    CMD_OFFSET  = 4'd3,
    CMD_ONESHOT = 4'd4,
    CMD_EXPIRE  = 4'd5,
    CMD_RESTART = 4'd6,
    CMD_ENABLE  = 4'd7,
    CMD_DISABLE = 4'd8
  } ptb_cmd_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic scan_step;
    logic flush;
    logic add_do;
    logic slot_do;
    logic mod_start;
    logic offset_do;
  } ptb_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic is_add;
    logic slot_ok;
    logic is_offset;
    logic reload_zero;
    logic scan_done;
    logic scan_hold;
    logic pend_valid;
    logic out_free;
    logic mod_done;
  } ptb_status_t;

endpackage

// File: hw/rtl/periodic_timer_bank_unit.sv
// Top level of the periodic timer bank: controller, datapath and remainder unit.
// Depends on ptb_pkg, ptb_ctrl and ptb_datapath.
//
//  channel  handshake              payload
//  input    in_valid_i/in_stall_o  cmd_i slot_i event_id_i amount_ms_i start_enabled_i
//                                  single_shot_i keep_phase_i
//  result   out_valid_o/out_stall_i kind_o slot_out_o event_out_o add_ok_o
//                                  overflow_error_o last_o
//  config   cfg_we_i               cfg_wdata_i (tick period in ms)
//
// One item is worked on at a time; the next is taken once the controller is back in idle.
// A slot command goes from decode straight back to idle, an add passes through the add state,
// a tick scans every allocated slot and then flushes, and an offset with a nonzero timeout
// waits on the one-bit-per-cycle remainder unit. An add or a tick that has a result to post
// waits while the result register stays stalled; other commands do not wait.
// Reset clears the allocation count and overflow flag; no clearing pass.
module periodic_timer_bank_unit import ptb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [AMT_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [EVT_W-1:0]  event_id_i,
  input  logic [AMT_W-1:0]  amount_ms_i,
  input  logic              start_enabled_i,
  input  logic              single_shot_i,
  input  logic              keep_phase_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [SLOT_W-1:0] slot_out_o,
  output logic [EVT_W-1:0]  event_out_o,
  output logic              add_ok_o,
  output logic              overflow_error_o,
  output logic              last_o
);

  ptb_ctrl_t   ctl;
  ptb_status_t sts;

  ptb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ptb_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .cmd_i            (cmd_i),
    .slot_i           (slot_i),
    .event_id_i       (event_id_i),
    .amount_ms_i      (amount_ms_i),
    .start_enabled_i  (start_enabled_i),
    .single_shot_i    (single_shot_i),
    .keep_phase_i     (keep_phase_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .slot_out_o       (slot_out_o),
    .event_out_o      (event_out_o),
    .add_ok_o         (add_ok_o),
    .overflow_error_o (overflow_error_o),
    .last_o           (last_o)
  );

endmodule

// File: hw/rtl/ptb_mod.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
// Depends on ptb_pkg for the operand width.
module ptb_mod import ptb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AMT_W-1:0] dividend_i,
  input  logic [AMT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [AMT_W-1:0] rem_o
);

  localparam int ITER_W = $clog2(AMT_W + 1);

  logic [AMT_W-1:0]  a_q, a_d;
  logic [AMT_W-1:0]  d_q, d_d;
  logic [AMT_W-1:0]  r_q, r_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [AMT_W:0]    trial;

  assign trial = {r_q, a_q[AMT_W-1]};

  always_comb begin
    a_d    = a_q;
    d_d    = d_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    done_d = done_q;
    if (start_i) begin
      a_d    = dividend_i;
      d_d    = divisor_i;
      r_d    = '0;
      cnt_d  = ITER_W'(AMT_W);
      done_d = 1'b0;
    end else if (cnt_q != '0) begin
      a_d   = {a_q[AMT_W-2:0], 1'b0};
      if (trial >= {1'b0, d_q}) begin
        r_d = AMT_W'(trial - {1'b0, d_q});
      end else begin
        r_d = trial[AMT_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    d_q <= d_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// File: hw/rtl/ptb_datapath.sv
// Timer storage, remaining-count arithmetic, expiry hold register and result register.
// Depends on ptb_pkg and instantiates ptb_mod.
module ptb_datapath import ptb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptb_ctrl_t         ctl_i,
  output ptb_status_t       sts_o,
  input  logic              cfg_we_i,
  input  logic [AMT_W-1:0]  cfg_wdata_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [EVT_W-1:0]  event_id_i,
  input  logic [AMT_W-1:0]  amount_ms_i,
  input  logic              start_enabled_i,
  input  logic              single_shot_i,
  input  logic              keep_phase_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              kind_o,
  output logic [SLOT_W-1:0] slot_out_o,
  output logic [EVT_W-1:0]  event_out_o,
  output logic              add_ok_o,
  output logic              overflow_error_o,
  output logic              last_o
);

  localparam int SUM_W = REM_W + 2;

  // Timer storage; a slot is written by add before any read, then updated by slot commands, offset and tick.
  logic [EVT_W-1:0]        ev_mem  [NUM_TIMERS];
  logic [AMT_W-1:0]        rl_mem  [NUM_TIMERS];
  logic signed [REM_W-1:0] rem_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]   en_mem;
  logic [NUM_TIMERS-1:0]   os_mem;

  logic [AMT_W-1:0]  period_q;
  logic [CNT_W-1:0]  used_q;
  logic              full_q;
  logic [CNT_W-1:0]  idx_q;

  // Latched input item.
  logic [CMD_W-1:0]  cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [EVT_W-1:0]  ev_q;
  logic [AMT_W-1:0]  amt_q;
  logic              sen_q;
  logic              sshot_q;
  logic              keep_q;

  // Expiry held back until the next one shows whether it is the last.
  logic              pend_valid_q;
  logic [SLOT_W-1:0] pend_slot_q;
  logic [EVT_W-1:0]  pend_ev_q;

  logic              out_valid_q;
  logic              kind_q;
  logic [SLOT_W-1:0] slot_out_q;
  logic [EVT_W-1:0]  ev_out_q;
  logic              ok_q;
  logic              ovf_q;
  logic              last_q;

  logic [SLOT_W-1:0]       acc_idx;
  logic [EVT_W-1:0]        ev_rd;
  logic [AMT_W-1:0]        rl_rd;
  logic signed [REM_W-1:0] rem_rd;
  logic                    en_rd;
  logic                    os_rd;
  logic signed [SUM_W-1:0] addend;
  logic signed [SUM_W-1:0] sum;
  logic signed [REM_W-1:0] sat_sum;
  logic                    expire;
  logic                    add_ok;
  logic                    out_free;
  logic                    scan_push;
  logic                    scan_hit;
  logic                    mod_done;
  logic [AMT_W-1:0]        mod_rem;

  assign acc_idx = (cmd_q == CMD_TICK) ? idx_q[SLOT_W-1:0] : slot_q;
  assign ev_rd   = ev_mem[acc_idx];
  assign rl_rd   = rl_mem[acc_idx];
  assign rem_rd  = rem_mem[acc_idx];
  assign en_rd   = en_mem[acc_idx];
  assign os_rd   = os_mem[acc_idx];

  // One shared adder serves tick, keep-phase timeout change and offset.
  always_comb begin
    case (cmd_q)
      CMD_TICK:   addend = -$signed({(SUM_W-AMT_W)'(0), period_q});
      CMD_SET_TO: addend = $signed({(SUM_W-AMT_W)'(0), amt_q})
                           - $signed({(SUM_W-AMT_W)'(0), rl_rd});
      default:    addend = -$signed({(SUM_W-AMT_W)'(0), mod_rem});
    endcase
  end

  assign sum = $signed({{(SUM_W-REM_W){rem_rd[REM_W-1]}}, rem_rd}) + addend;

  always_comb begin
    if (sum[SUM_W-1:REM_W-1] == '0 || sum[SUM_W-1:REM_W-1] == '1) begin
      sat_sum = sum[REM_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_sum = {1'b1, {(REM_W-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(REM_W-1){1'b1}}};
    end
  end

  assign expire    = sat_sum[REM_W-1] || (sat_sum == '0);
  assign add_ok    = !full_q && (used_q < CNT_W'(NUM_TIMERS));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign scan_hit  = ctl_i.scan_step && en_rd && expire;
  assign scan_push = scan_hit && pend_valid_q;

  ptb_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.mod_start),
    .dividend_i (amt_q),
    .divisor_i  (rl_rd),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  always_comb begin
    sts_o.is_tick     = (cmd_q == CMD_TICK);
    sts_o.is_add      = (cmd_q == CMD_ADD);
    sts_o.slot_ok     = (cmd_q inside {[CMD_SET_TO:CMD_DISABLE]})
                        && ({1'b0, slot_q} < used_q);
    sts_o.is_offset   = (cmd_q == CMD_OFFSET);
    sts_o.reload_zero = (rl_rd == '0);
    sts_o.scan_done   = (idx_q >= used_q);
    sts_o.scan_hold   = en_rd && expire && pend_valid_q && !out_free;
    sts_o.pend_valid  = pend_valid_q;
    sts_o.out_free    = out_free;
    sts_o.mod_done    = mod_done;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= AMT_W'(1);
      used_q       <= '0;
      full_q       <= 1'b0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (ctl_i.add_do) begin
        if (add_ok) begin
          used_q <= used_q + 1'b1;
        end else begin
          full_q <= 1'b1;
        end
      end
      if (ctl_i.latch) begin
        idx_q        <= '0;
        pend_valid_q <= 1'b0;
      end else if (ctl_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (scan_hit) begin
          pend_valid_q <= 1'b1;
        end
      end else if (ctl_i.flush) begin
        pend_valid_q <= 1'b0;
      end
      if (ctl_i.add_do || ctl_i.flush || scan_push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and timer storage.
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q   <= cmd_i;
      slot_q  <= slot_i;
      ev_q    <= event_id_i;
      amt_q   <= amount_ms_i;
      sen_q   <= start_enabled_i;
      sshot_q <= single_shot_i;
      keep_q  <= keep_phase_i;
    end

    if (ctl_i.add_do && add_ok) begin
      ev_mem[used_q[SLOT_W-1:0]]  <= ev_q;
      rl_mem[used_q[SLOT_W-1:0]]  <= amt_q;
      rem_mem[used_q[SLOT_W-1:0]] <= $signed({(REM_W-AMT_W)'(0), amt_q});
      en_mem[used_q[SLOT_W-1:0]]  <= sen_q;
      os_mem[used_q[SLOT_W-1:0]]  <= sshot_q;
    end

    if (ctl_i.slot_do) begin
      case (cmd_q)
        CMD_SET_TO: begin
          if (keep_q) begin
            rem_mem[acc_idx] <= sat_sum;
          end
          rl_mem[acc_idx] <= amt_q;
        end
        CMD_ONESHOT: os_mem[acc_idx]  <= 1'b1;
        CMD_EXPIRE:  rem_mem[acc_idx] <= '0;
        CMD_RESTART: rem_mem[acc_idx] <= $signed({(REM_W-AMT_W)'(0), rl_rd});
        CMD_ENABLE:  en_mem[acc_idx]  <= 1'b1;
        CMD_DISABLE: en_mem[acc_idx]  <= 1'b0;
        default: ;
      endcase
    end

    if (ctl_i.offset_do) begin
      rem_mem[acc_idx] <= sat_sum;
    end

    if (ctl_i.scan_step && en_rd) begin
      if (expire) begin
        rem_mem[acc_idx] <= $signed({(REM_W-AMT_W)'(0), rl_rd});
        if (os_rd) begin
          en_mem[acc_idx] <= 1'b0;
        end
      end else begin
        rem_mem[acc_idx] <= sat_sum;
      end
    end

    if (scan_hit) begin
      pend_slot_q <= acc_idx;
      pend_ev_q   <= ev_rd;
    end

    if (ctl_i.add_do) begin
      kind_q     <= 1'b0;
      slot_out_q <= add_ok ? used_q[SLOT_W-1:0] : '0;
      ev_out_q   <= '0;
      ok_q       <= add_ok;
      ovf_q      <= full_q || !add_ok;
      last_q     <= 1'b1;
    end else if (ctl_i.flush || scan_push) begin
      kind_q     <= 1'b1;
      slot_out_q <= pend_slot_q;
      ev_out_q   <= pend_ev_q;
      ok_q       <= 1'b0;
      ovf_q      <= full_q;
      last_q     <= ctl_i.flush;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign slot_out_o       = slot_out_q;
  assign event_out_o      = ev_out_q;
  assign add_ok_o         = ok_q;
  assign overflow_error_o = ovf_q;
  assign last_o           = last_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(NUM_TIMERS))
    else $error("allocated count beyond bank size");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.add_do || ctl_i.flush || scan_push) |-> out_free)
    else $error("result written while result register is occupied");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("overflow flag cleared");

  a_mod_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.mod_start |-> (rl_rd != '0))
    else $error("remainder started with zero timeout");

endmodule

// File: hw/rtl/ptb_ctrl.sv
// Controller state machine for the periodic timer bank.
// Depends on ptb_pkg for the command and status structs.
module ptb_ctrl import ptb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ptb_status_t sts_i,
  output ptb_ctrl_t   ctl_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_ADD    = 3'd4;
  localparam logic [2:0] S_MOD    = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_tick) begin
          state_d = S_SCAN;
        end else if (sts_i.is_add) begin
          state_d = S_ADD;
        end else if (sts_i.slot_ok && sts_i.is_offset) begin
          if (sts_i.reload_zero) begin
            state_d = S_IDLE;
          end else begin
            ctl_o.mod_start = 1'b1;
            state_d         = S_MOD;
          end
        end else begin
          ctl_o.slot_do = sts_i.slot_ok;
          state_d       = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = S_FLUSH;
        end else if (!sts_i.scan_hold) begin
          ctl_o.scan_step = 1'b1;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          ctl_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_ADD: begin
        if (sts_i.out_free) begin
          ctl_o.add_do = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          ctl_o.offset_do = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule
